// File: hw/rtl/rls_pkg.sv
package rls_pkg;

    localparam int MAX_LEDS     = 1024;
    localparam int ADDR_W       = $clog2(MAX_LEDS);
    localparam int LED_CNT_W    = 11;
    localparam int TIMING_W     = 16;
    localparam int COLOR_W      = 8;
    localparam int COLORS       = 3;
    localparam int PIXEL_W      = COLOR_W * COLORS;
    localparam int BIT_PTR_W    = $clog2(PIXEL_W);
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = TIMING_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_SET      = 3'd1,
        CMD_SET_SHOW = 3'd2,
        CMD_SHOW     = 3'd3,
        CMD_CLEAR    = 3'd4
    } rls_cmd_code_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_BUSY  = 2'd2
    } rls_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LED_COUNT  = 3'd0,
        REG_ZERO_HIGH  = 3'd1,
        REG_ONE_HIGH   = 3'd2,
        REG_BIT_PERIOD = 3'd3,
        REG_LATCH_LOW  = 3'd4
    } rls_reg_t;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_IDLE,
        PH_LATCH,
        PH_DATA
    } rls_state_t;

    // Controller to datapath
    typedef struct packed {
        logic store_write;
        logic start;
        logic clr_frame;
        logic cnt_inc;
        logic cnt_clr;
        logic shift;
        logic bit_inc;
        logic bit_clr;
        logic pix_inc;
        logic pix_clr;
        logic load;
        logic clearing_clr;
        logic init_write;
        logic rd_next;
    } rls_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic idx_ok;
        logic latch_end;
        logic bit_end;
        logic last_bit;
        logic last_pixel;
        logic empty;
        logic line;
        logic init_last;
    } rls_stat_t;

endpackage

// File: hw/rtl/rls_cmd_if.sv
interface rls_cmd_if;
    import rls_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      command;
    logic [ADDR_W-1:0]     pixel_index;
    logic [COLOR_W-1:0]    red_level;
    logic [COLOR_W-1:0]    green_level;
    logic [COLOR_W-1:0]    blue_level;

    modport source (
        output valid, command, pixel_index, red_level, green_level, blue_level,
        input  ready
    );

    modport sink (
        input  valid, command, pixel_index, red_level, green_level, blue_level,
        output ready
    );
endinterface

// File: hw/rtl/rls_res_if.sv
interface rls_res_if;
    import rls_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  line_level;
    logic [STATUS_W-1:0]   status;
    logic                  sending;
    logic                  frame_done;

    modport source (
        output valid, line_level, status, sending, frame_done,
        input  ready
    );

    modport sink (
        input  valid, line_level, status, sending, frame_done,
        output ready
    );
endinterface

// File: hw/rtl/rls_datapath.sv
module rls_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [rls_pkg::ADDR_W-1:0]  pixel_index,
    input  logic [rls_pkg::COLOR_W-1:0] red_level,
    input  logic [rls_pkg::COLOR_W-1:0] green_level,
    input  logic [rls_pkg::COLOR_W-1:0] blue_level,
    input  rls_pkg::rls_cmd_t           cmd,
    output rls_pkg::rls_stat_t          stat
);
    import rls_pkg::*;

    logic [LED_CNT_W-1:0] led_count_reg;
    logic [TIMING_W-1:0]  zero_high_reg;
    logic [TIMING_W-1:0]  one_high_reg;
    logic [TIMING_W-1:0]  period_reg;
    logic [TIMING_W-1:0]  latch_reg;

    logic [TIMING_W-1:0]  cycle_count_reg, cycle_count_next;
    logic [BIT_PTR_W-1:0] bit_ptr_reg, bit_ptr_next;
    logic [ADDR_W-1:0]    pix_ptr_reg, pix_ptr_next;
    logic [PIXEL_W-1:0]   shift_reg, shift_next;
    logic                 clearing_reg, clearing_next;
    logic [ADDR_W-1:0]    init_addr_reg;

    logic [PIXEL_W-1:0]   mem [MAX_LEDS];
    logic [PIXEL_W-1:0]   rd_data_reg;

    logic [LED_CNT_W-1:0] live_count;
    logic [TIMING_W-1:0]  cnt_plus1;
    logic [TIMING_W-1:0]  latch_lim;
    logic [TIMING_W-1:0]  period_lim;
    logic [TIMING_W-1:0]  high_time;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [PIXEL_W-1:0]   mem_wd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_CNT_W'(24);
            zero_high_reg <= TIMING_W'(6);
            one_high_reg  <= TIMING_W'(11);
            period_reg    <= TIMING_W'(20);
            latch_reg     <= TIMING_W'(800);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LED_COUNT:  led_count_reg <= cfg_data[LED_CNT_W-1:0];
                REG_ZERO_HIGH:  zero_high_reg <= cfg_data;
                REG_ONE_HIGH:   one_high_reg  <= cfg_data;
                REG_BIT_PERIOD: period_reg    <= cfg_data;
                REG_LATCH_LOW:  latch_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign live_count = (led_count_reg > LED_CNT_W'(MAX_LEDS)) ?
                        LED_CNT_W'(MAX_LEDS) : led_count_reg;
    assign cnt_plus1  = cycle_count_reg + TIMING_W'(1);
    assign latch_lim  = (latch_reg == '0) ? TIMING_W'(1) : latch_reg;
    assign period_lim = (period_reg == '0) ? TIMING_W'(1) : period_reg;
    assign high_time  = shift_reg[PIXEL_W-1] ? one_high_reg : zero_high_reg;

    always_comb
    begin
        stat.idx_ok     = {1'b0, pixel_index} < live_count;
        stat.latch_end  = cnt_plus1 >= latch_lim;
        stat.bit_end    = cnt_plus1 >= period_lim;
        stat.last_bit   = bit_ptr_reg == BIT_PTR_W'(PIXEL_W - 1);
        stat.last_pixel = ({1'b0, pix_ptr_reg} + LED_CNT_W'(1)) >= live_count;
        stat.empty      = live_count == '0;
        stat.line       = cycle_count_reg < high_time;
        stat.init_last  = init_addr_reg == ADDR_W'(MAX_LEDS - 1);
    end

    // Frame sequencing registers
    always_comb
    begin
        cycle_count_next = cycle_count_reg;
        bit_ptr_next     = bit_ptr_reg;
        pix_ptr_next     = pix_ptr_reg;
        shift_next       = shift_reg;
        clearing_next    = clearing_reg;
        if (cmd.start)
        begin
            cycle_count_next = '0;
            bit_ptr_next     = '0;
            pix_ptr_next     = '0;
            shift_next       = '0;
            clearing_next    = cmd.clr_frame;
        end
        else
        begin
            if (cmd.cnt_clr)
                cycle_count_next = '0;
            else if (cmd.cnt_inc)
                cycle_count_next = cnt_plus1;
            if (cmd.bit_clr)
                bit_ptr_next = '0;
            else if (cmd.bit_inc)
                bit_ptr_next = bit_ptr_reg + BIT_PTR_W'(1);
            if (cmd.pix_clr)
                pix_ptr_next = '0;
            else if (cmd.pix_inc)
                pix_ptr_next = pix_ptr_reg + ADDR_W'(1);
            if (cmd.load)
                shift_next = clearing_reg ? '0 : rd_data_reg;
            else if (cmd.shift)
                shift_next = {shift_reg[PIXEL_W-2:0], 1'b0};
            if (cmd.clearing_clr)
                clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg <= '0;
            bit_ptr_reg     <= '0;
            pix_ptr_reg     <= '0;
            shift_reg       <= '0;
            clearing_reg    <= 1'b0;
            init_addr_reg   <= '0;
        end
        else
        begin
            cycle_count_reg <= cycle_count_next;
            bit_ptr_reg     <= bit_ptr_next;
            pix_ptr_reg     <= pix_ptr_next;
            shift_reg       <= shift_next;
            clearing_reg    <= clearing_next;
            if (cmd.init_write)
                init_addr_reg <= init_addr_reg + ADDR_W'(1);
        end
    end

    // Prefetch the pixel the next load takes
    assign rd_addr = cmd.rd_next ? (pix_ptr_reg + ADDR_W'(1)) : '0;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = rd_addr;
        mem_wd = '0;
        priority if (cmd.init_write)
        begin
            mem_we = 1'b1;
            mem_wa = init_addr_reg;
        end
        else if (cmd.store_write)
        begin
            mem_we = 1'b1;
            mem_wa = pixel_index;
            mem_wd = {green_level, red_level, blue_level};
        end
        else if (cmd.load && clearing_reg)
        begin
            mem_we = 1'b1;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_we && (mem_wa == rd_addr))
            rd_data_reg <= mem_wd;
        else
            rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/rls_controller.sv
module rls_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rls_pkg::CMD_W-1:0]     command,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          line_level,
    output logic [rls_pkg::STATUS_W-1:0]  status,
    output logic                          sending,
    output logic                          frame_done,
    input  rls_pkg::rls_stat_t            stat,
    output rls_pkg::rls_cmd_t             cmd
);
    import rls_pkg::*;

    rls_state_t           state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 line_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 sending_reg;
    logic                 done_reg;

    logic                 fire;
    logic                 real_cmd;
    logic                 line_now;
    rls_status_t          status_now;
    logic                 done_now;

    assign in_ready = (state_reg != PH_INIT) && (!out_valid_reg || out_ready);
    assign fire     = in_valid && in_ready;
    assign real_cmd = (command == CMD_SET) || (command == CMD_SET_SHOW) ||
                      (command == CMD_SHOW) || (command == CMD_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        line_now   = 1'b0;
        status_now = STAT_OK;
        done_now   = 1'b0;
        cmd.rd_next = (state_reg == PH_DATA);
        unique case (state_reg)
            PH_INIT:
            begin
                cmd.init_write = 1'b1;
                if (stat.init_last)
                    state_next = PH_IDLE;
            end
            PH_IDLE:
            begin
                if (fire)
                begin
                    unique case (command)
                        CMD_SET, CMD_SET_SHOW:
                        begin
                            if (stat.idx_ok)
                            begin
                                cmd.store_write = 1'b1;
                                if (command == CMD_SET_SHOW)
                                begin
                                    cmd.start  = 1'b1;
                                    state_next = PH_LATCH;
                                end
                            end
                            else
                            begin
                                status_now = STAT_RANGE;
                            end
                        end
                        CMD_SHOW:
                        begin
                            cmd.start  = 1'b1;
                            state_next = PH_LATCH;
                        end
                        CMD_CLEAR:
                        begin
                            cmd.start     = 1'b1;
                            cmd.clr_frame = 1'b1;
                            state_next    = PH_LATCH;
                        end
                        default: ;
                    endcase
                end
            end
            PH_LATCH:
            begin
                if (fire)
                begin
                    if (real_cmd)
                        status_now = STAT_BUSY;
                    cmd.cnt_inc = 1'b1;
                    if (stat.latch_end)
                    begin
                        cmd.pix_clr = 1'b1;
                        cmd.cnt_clr = 1'b1;
                        if (stat.empty)
                        begin
                            cmd.clearing_clr = 1'b1;
                            done_now         = 1'b1;
                            state_next       = PH_IDLE;
                        end
                        else
                        begin
                            cmd.load    = 1'b1;
                            cmd.bit_clr = 1'b1;
                            state_next  = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                if (fire)
                begin
                    if (real_cmd)
                        status_now = STAT_BUSY;
                    line_now = stat.line;
                    if (stat.bit_end)
                    begin
                        cmd.cnt_clr = 1'b1;
                        cmd.shift   = 1'b1;
                        if (stat.last_bit)
                        begin
                            cmd.bit_clr = 1'b1;
                            cmd.pix_inc = 1'b1;
                            if (stat.last_pixel)
                            begin
                                cmd.clearing_clr = 1'b1;
                                done_now         = 1'b1;
                                state_next       = PH_IDLE;
                            end
                            else
                            begin
                                cmd.load = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.bit_inc = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: capture on each transaction
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            line_reg    <= line_now;
            status_reg  <= status_now;
            sending_reg <= (state_next != PH_IDLE);
            done_reg    <= done_now;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = line_reg;
    assign status     = status_reg;
    assign sending    = sending_reg;
    assign frame_done = done_reg;

endmodule

// File: hw/rtl/rgb_led_strip_serializer_top.sv
// Serializer for a strip of tricolor LEDs driven over one data line.
//
// cmd_ch carries one command per transaction: tick, set color, set color and
// show, show or clear, with a pixel index and red, green and blue levels.
// Every transaction is one clock of the line waveform. res_ch returns exactly
// one result per command transaction: the line level after it, a status
// (ok, index out of range, busy), a sending flag and a frame-done pulse.
// The cfg_we / cfg_index / cfg_data port writes the LED count and the
// zero-high, one-high, bit-period and latch-low timings; write only while idle.
//
// A result is registered and valid in the cycle after its command transaction.
// Throughput: one command per cycle while res_ch is ready; the single output
// register lets a new command in during the cycle its predecessor's result is
// taken. The pixel store is one 1024 x 24 memory with one write and one
// registered read port; the next pixel is prefetched during each bit sweep.
// Reset: the pixel store is cleared by a pass over all 1024 entries, one entry per
// cycle; cmd_ch.ready stays low until it ends, config writes are still taken.
// Stall: when res_ch holds a result that is not taken, cmd_ch.ready drops and
// the waveform does not advance until the result leaves.
module rgb_led_strip_serializer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]  cfg_data,
    rls_cmd_if.sink                         cmd_ch,
    rls_res_if.source                       res_ch
);
    import rls_pkg::*;

    rls_cmd_t  dp_cmd;
    rls_stat_t dp_stat;

    // Sequencing: phase state, command decode and the result register
    rls_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd_ch.valid),
        .in_ready   (cmd_ch.ready),
        .command    (cmd_ch.command),
        .out_valid  (res_ch.valid),
        .out_ready  (res_ch.ready),
        .line_level (res_ch.line_level),
        .status     (res_ch.status),
        .sending    (res_ch.sending),
        .frame_done (res_ch.frame_done),
        .stat       (dp_stat),
        .cmd        (dp_cmd)
    );

    // Storage, timing counters, shift word and configuration registers
    rls_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_index (cmd_ch.pixel_index),
        .red_level   (cmd_ch.red_level),
        .green_level (cmd_ch.green_level),
        .blue_level  (cmd_ch.blue_level),
        .cmd         (dp_cmd),
        .stat        (dp_stat)
    );

endmodule

// File: hw/rtl/rls_checker.sv
module rls_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_valid,
    input  logic                           res_ready,
    input  logic                           line_level,
    input  logic [rls_pkg::STATUS_W-1:0]   status,
    input  logic                           sending,
    input  logic                           frame_done
);
    import rls_pkg::*;

    // A finished frame never reports itself as still sending
    a_done_not_sending: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_done |-> !sending)
        else $error("frame_done with sending set");

    // A rejected set happens only while idle with the line low
    a_range_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == STAT_RANGE) |-> !sending && !line_level && !frame_done)
        else $error("range error outside idle");

    // Idle outside the finishing item keeps the line low
    a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !sending && !frame_done |-> !line_level)
        else $error("line high while idle");

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) &&
        $stable(line_level) && $stable(sending) && $stable(frame_done))
        else $error("result changed while stalled");

endmodule

bind rgb_led_strip_serializer_top rls_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_ch.valid),
    .res_ready  (res_ch.ready),
    .line_level (res_ch.line_level),
    .status     (res_ch.status),
    .sending    (res_ch.sending),
    .frame_done (res_ch.frame_done)
);
